// ===== design/ffa_pkg.sv =====
// Shared types, sizes and codes for the first-fit page segment allocator.
package ffa_pkg;

  // Sizes of the managed space and of the two tables
  localparam int MAX_SEGMENTS = 16;
  localparam int HOLE_DEPTH   = MAX_SEGMENTS + 1;
  localparam int MAX_PAGES    = 4096;

  localparam int PID_W   = 16;
  localparam int PAGE_W  = 12;
  localparam int COUNT_W = 13;
  localparam int SEG_N_W = 5;
  localparam int HOLE_N_W = 5;
  localparam int SEG_IDX_W = 4;

  // Operation codes
  localparam logic [1:0] OP_ALLOCATE  = 2'd0;
  localparam logic [1:0] OP_RELEASE   = 2'd1;
  localparam logic [1:0] OP_COMPACT   = 2'd2;
  localparam logic [1:0] OP_TRANSLATE = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_HOLE    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  // Cell commands
  localparam logic [2:0] CELL_HOLD  = 3'd0;
  localparam logic [2:0] CELL_PREV  = 3'd1;
  localparam logic [2:0] CELL_NEXT  = 3'd2;
  localparam logic [2:0] CELL_LOAD  = 3'd3;
  localparam logic [2:0] CELL_CLEAR = 3'd4;

  typedef struct packed {
    logic                 valid;
    logic [PID_W-1:0]     pid;
    logic [PAGE_W-1:0]    base;
    logic [COUNT_W-1:0]   len;
  } seg_entry_t;

  typedef struct packed {
    logic                 valid;
    logic [PAGE_W-1:0]    base;
    logic [COUNT_W-1:0]   len;
  } hole_entry_t;

  typedef struct packed {
    logic [2:0]  sel;
    seg_entry_t  data;
  } seg_ctl_t;

  typedef struct packed {
    logic [2:0]  sel;
    hole_entry_t data;
  } hole_ctl_t;

endpackage

// ===== design/first_fit_page_segment_allocator.sv =====
// Top level of the first-fit page segment allocator: sequencer over two cell chains.
//
//  channel   | direction | handshake               | carries
//  s_axis    | in        | s_axis_tvalid/tready    | one operation item
//  m_axis    | out       | m_axis_tvalid/tready    | result items, tlast on the final one
//  cfg       | in        | cfg_wr_en               | total_pages, no wait
//
//  Allocate picks a hole, then carves it; release finds the segment, drops it, then merges
//  holes; compact rebuilds the holes, then moves the segments down in order. A rejected
//  allocate or release ends in its first state.
//  One item is worked at a time; a result waits in the output register and
//  the sequencer stalls only when it must emit and that register is still full.
//  Reset (rst, synchronous) empties the segment chain and leaves one hole of
//  4096 pages; a total_pages write does the same for the new size.
module first_fit_page_segment_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // pid[15:0], request_pages[28:16], logical_page[40:29]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // status[1:0], address[13:2], source_address[25:14],
                                     // page_count[38:26], free_pages[51:39]
  output logic        m_axis_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data
);

  localparam int NS = ffa_pkg::MAX_SEGMENTS;
  localparam int NH = ffa_pkg::HOLE_DEPTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AL1  = 4'd1;
  localparam logic [3:0] S_AL2  = 4'd2;
  localparam logic [3:0] S_RL1  = 4'd3;
  localparam logic [3:0] S_RL2  = 4'd4;
  localparam logic [3:0] S_RL3  = 4'd5;
  localparam logic [3:0] S_TR   = 4'd6;
  localparam logic [3:0] S_CP0  = 4'd7;
  localparam logic [3:0] S_CP1  = 4'd8;
  localparam logic [3:0] S_CPZ  = 4'd9;

  ffa_pkg::seg_entry_t  seg [NS];
  ffa_pkg::hole_entry_t hole [NH];
  ffa_pkg::seg_ctl_t    seg_ctl [NS];
  ffa_pkg::hole_ctl_t   hole_ctl [NH];

  logic [3:0]  state, state_next;
  logic [15:0] op_pid, op_pid_next;
  logic [12:0] op_req, op_req_next;
  logic [11:0] op_lp, op_lp_next;
  logic [4:0]  seg_n, seg_n_next;
  logic [4:0]  hole_n, hole_n_next;
  logic [12:0] free_total, free_next;
  logic [12:0] total_pages, total_next;
  logic [3:0]  idx_f, idx_f_next;
  logic [4:0]  h_idx, h_idx_next;
  logic [11:0] h_base, h_base_next;
  logic [12:0] h_len, h_len_next;
  logic [11:0] r_base, r_base_next;
  logic [12:0] r_len, r_len_next;
  ffa_pkg::hole_entry_t left_ent, left_next, right_ent, right_next;
  logic [12:0] run, run_next;
  logic [3:0]  k, k_next;

  logic        emit;
  logic [1:0]  e_status;
  logic [11:0] e_addr, e_src;
  logic [12:0] e_cnt;
  logic        e_last;
  logic        can_emit;

  // Search results over the chains
  logic                 pid_hit;
  logic [3:0]           f_idx;
  ffa_pkg::seg_entry_t  seg_f;
  logic                 fit_hit;
  logic [4:0]           fit_idx;
  ffa_pkg::hole_entry_t fit_ent;
  logic [4:0]           seg_pos;
  logic [4:0]           hole_pos;
  ffa_pkg::hole_entry_t hole_at, hole_before;
  ffa_pkg::seg_entry_t  seg_k;
  logic [12:0]          cfg_sat, used;
  logic                 lft, rgt;
  logic [NS-1:0]        seg_vld;
  logic [NH-1:0]        hole_vld;

  // Cell chains
  for (genvar g = 0; g < NS; g++) begin : g_seg
    ffa_seg_cell u_cell (
      .clk      (clk),
      .ctl      (seg_ctl[g]),
      .prev_ent ((g == 0) ? ffa_pkg::seg_entry_t'('0) : seg[(g == 0) ? 0 : g - 1]),
      .next_ent ((g == NS - 1) ? ffa_pkg::seg_entry_t'('0) : seg[(g == NS - 1) ? g : g + 1]),
      .ent      (seg[g])
    );
    assign seg_vld[g] = seg[g].valid;
  end

  for (genvar g = 0; g < NH; g++) begin : g_hole
    ffa_hole_cell u_cell (
      .clk      (clk),
      .ctl      (hole_ctl[g]),
      .prev_ent ((g == 0) ? ffa_pkg::hole_entry_t'('0) : hole[(g == 0) ? 0 : g - 1]),
      .next_ent ((g == NH - 1) ? ffa_pkg::hole_entry_t'('0) : hole[(g == NH - 1) ? g : g + 1]),
      .ent      (hole[g])
    );
    assign hole_vld[g] = hole[g].valid;
  end

  assign s_axis_tready = (state == S_IDLE);
  assign can_emit      = !m_axis_tvalid || m_axis_tready;

  // Find the first matching cell of each chain
  always_comb begin
    pid_hit  = 1'b0;
    f_idx    = '0;
    fit_hit  = 1'b0;
    fit_idx  = '0;
    seg_pos  = 5'(NS);
    hole_pos = 5'(NH);
    for (int i = NS - 1; i >= 0; i--) begin
      if (seg[i].valid && seg[i].pid == op_pid) begin
        pid_hit = 1'b1;
        f_idx   = 4'(i);
      end
      if (!(seg[i].valid && seg[i].base < h_base)) seg_pos = 5'(i);
    end
    for (int i = NH - 1; i >= 0; i--) begin
      if (hole[i].valid && hole[i].len >= op_req) begin
        fit_hit = 1'b1;
        fit_idx = 5'(i);
      end
      if (!(hole[i].valid && hole[i].base < r_base)) hole_pos = 5'(i);
    end
  end

  // Read selected cells through one-hot and-or muxes
  always_comb begin
    seg_f       = '0;
    seg_k       = '0;
    fit_ent     = '0;
    hole_at     = '0;
    hole_before = '0;
    for (int i = 0; i < NS; i++) begin
      if (4'(i) == f_idx) seg_f = seg_f | seg[i];
      if (4'(i) == k)     seg_k = seg_k | seg[i];
    end
    for (int i = 0; i < NH; i++) begin
      if (5'(i) == fit_idx)        fit_ent     = fit_ent | hole[i];
      if (5'(i) == hole_pos)       hole_at     = hole_at | hole[i];
      if (5'(i) + 5'd1 == hole_pos) hole_before = hole_before | hole[i];
    end
  end

  assign cfg_sat = (cfg_wr_data == 13'd0) ? 13'd1 :
                   (cfg_wr_data > 13'(ffa_pkg::MAX_PAGES)) ? 13'(ffa_pkg::MAX_PAGES) :
                   cfg_wr_data;
  assign used = total_pages - free_total;
  assign lft  = left_ent.valid && ({1'b0, left_ent.base} + left_ent.len == {1'b0, r_base});
  assign rgt  = right_ent.valid && ({1'b0, r_base} + r_len == {1'b0, right_ent.base});

  // Sequencer: steer the cells and build the result
  always_comb begin
    state_next  = state;
    op_pid_next = op_pid;
    op_req_next = op_req;
    op_lp_next  = op_lp;
    seg_n_next  = seg_n;
    hole_n_next = hole_n;
    free_next   = free_total;
    total_next  = total_pages;
    idx_f_next  = idx_f;
    h_idx_next  = h_idx;
    h_base_next = h_base;
    h_len_next  = h_len;
    r_base_next = r_base;
    r_len_next  = r_len;
    left_next   = left_ent;
    right_next  = right_ent;
    run_next    = run;
    k_next      = k;
    emit        = 1'b0;
    e_status    = ffa_pkg::ST_OK;
    e_addr      = '0;
    e_src       = '0;
    e_cnt       = '0;
    e_last      = 1'b1;
    for (int i = 0; i < NS; i++) seg_ctl[i] = '{sel: ffa_pkg::CELL_HOLD, data: '0};
    for (int i = 0; i < NH; i++) hole_ctl[i] = '{sel: ffa_pkg::CELL_HOLD, data: '0};

    if (rst) begin
      for (int i = 0; i < NS; i++) seg_ctl[i].sel = ffa_pkg::CELL_CLEAR;
      for (int i = 1; i < NH; i++) hole_ctl[i].sel = ffa_pkg::CELL_CLEAR;
      hole_ctl[0] = '{sel: ffa_pkg::CELL_LOAD,
                      data: '{valid: 1'b1, base: '0, len: 13'(ffa_pkg::MAX_PAGES)}};
    end else if (cfg_wr_en) begin
      // Reinitialise the space for the new size
      total_next  = cfg_sat;
      seg_n_next  = '0;
      hole_n_next = 5'd1;
      free_next   = cfg_sat;
      for (int i = 0; i < NS; i++) seg_ctl[i].sel = ffa_pkg::CELL_CLEAR;
      for (int i = 1; i < NH; i++) hole_ctl[i].sel = ffa_pkg::CELL_CLEAR;
      hole_ctl[0] = '{sel: ffa_pkg::CELL_LOAD,
                      data: '{valid: 1'b1, base: '0, len: cfg_sat}};
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_pid_next = s_axis_tdata[15:0];
            op_req_next = s_axis_tdata[28:16];
            op_lp_next  = s_axis_tdata[40:29];
            case (s_axis_tuser)
              ffa_pkg::OP_ALLOCATE: state_next = S_AL1;
              ffa_pkg::OP_RELEASE:  state_next = S_RL1;
              ffa_pkg::OP_COMPACT:  state_next = S_CP0;
              default:              state_next = S_TR;
            endcase
          end
        end
        S_AL1: begin
          // Pick the first hole that fits, or reject when the segment table is full or no hole fits
          if (seg_n == 5'(NS)) begin
            if (can_emit) begin
              emit       = 1'b1;
              e_status   = ffa_pkg::ST_TABLE_FULL;
              state_next = S_IDLE;
            end
          end else if (op_req == 13'd0 || !fit_hit) begin
            if (can_emit) begin
              emit       = 1'b1;
              e_status   = ffa_pkg::ST_NO_HOLE;
              state_next = S_IDLE;
            end
          end else begin
            h_idx_next  = fit_idx;
            h_base_next = fit_ent.base;
            h_len_next  = fit_ent.len;
            state_next  = S_AL2;
          end
        end
        S_AL2: begin
          // Carve the hole and insert the segment in base order
          if (can_emit) begin
            if (h_len == op_req) begin
              for (int i = 0; i < NH; i++)
                if (5'(i) >= h_idx) hole_ctl[i].sel = ffa_pkg::CELL_NEXT;
              hole_n_next = hole_n - 5'd1;
            end else begin
              for (int i = 0; i < NH; i++)
                if (5'(i) == h_idx)
                  hole_ctl[i] = '{sel: ffa_pkg::CELL_LOAD,
                                  data: '{valid: 1'b1,
                                          base: h_base + op_req[11:0],
                                          len: h_len - op_req}};
            end
            for (int i = 0; i < NS; i++) begin
              if (5'(i) > seg_pos) seg_ctl[i].sel = ffa_pkg::CELL_PREV;
              else if (5'(i) == seg_pos)
                seg_ctl[i] = '{sel: ffa_pkg::CELL_LOAD,
                               data: '{valid: 1'b1, pid: op_pid, base: h_base,
                                       len: op_req}};
            end
            seg_n_next = seg_n + 5'd1;
            free_next  = free_total - op_req;
            emit       = 1'b1;
            e_addr     = h_base;
            e_cnt      = op_req;
            state_next = S_IDLE;
          end
        end
        S_RL1: begin
          if (!pid_hit) begin
            if (can_emit) begin
              emit       = 1'b1;
              e_status   = ffa_pkg::ST_NOT_FOUND;
              state_next = S_IDLE;
            end
          end else begin
            idx_f_next  = f_idx;
            r_base_next = seg_f.base;
            r_len_next  = seg_f.len;
            state_next  = S_RL2;
          end
        end
        S_RL2: begin
          // Drop the segment and fetch the holes around it
          for (int i = 0; i < NS; i++)
            if (4'(i) >= idx_f) seg_ctl[i].sel = ffa_pkg::CELL_NEXT;
          seg_n_next = seg_n - 5'd1;
          h_idx_next = hole_pos;
          left_next  = hole_before;
          right_next = hole_at;
          state_next = S_RL3;
        end
        S_RL3: begin
          // Merge with neighbouring holes or insert a new one
          if (can_emit) begin
            for (int i = 0; i < NH; i++) begin
              if (lft && rgt) begin
                if (5'(i) + 5'd1 == h_idx)
                  hole_ctl[i] = '{sel: ffa_pkg::CELL_LOAD,
                                  data: '{valid: 1'b1, base: left_ent.base,
                                          len: left_ent.len + r_len + right_ent.len}};
                else if (5'(i) >= h_idx) hole_ctl[i].sel = ffa_pkg::CELL_NEXT;
              end else if (lft) begin
                if (5'(i) + 5'd1 == h_idx)
                  hole_ctl[i] = '{sel: ffa_pkg::CELL_LOAD,
                                  data: '{valid: 1'b1, base: left_ent.base,
                                          len: left_ent.len + r_len}};
              end else if (rgt) begin
                if (5'(i) == h_idx)
                  hole_ctl[i] = '{sel: ffa_pkg::CELL_LOAD,
                                  data: '{valid: 1'b1, base: r_base,
                                          len: right_ent.len + r_len}};
              end else if (hole_n < 5'(NH)) begin
                if (5'(i) > h_idx) hole_ctl[i].sel = ffa_pkg::CELL_PREV;
                else if (5'(i) == h_idx)
                  hole_ctl[i] = '{sel: ffa_pkg::CELL_LOAD,
                                  data: '{valid: 1'b1, base: r_base, len: r_len}};
              end
            end
            if (lft && rgt) hole_n_next = hole_n - 5'd1;
            else if (!lft && !rgt && hole_n < 5'(NH)) hole_n_next = hole_n + 5'd1;
            free_next  = free_total + r_len;
            emit       = 1'b1;
            e_addr     = r_base;
            e_cnt      = r_len;
            state_next = S_IDLE;
          end
        end
        S_TR: begin
          if (can_emit) begin
            emit       = 1'b1;
            state_next = S_IDLE;
            if (!pid_hit) begin
              e_status = ffa_pkg::ST_NOT_FOUND;
            end else begin
              e_addr = seg_f.base + op_lp;
              e_cnt  = seg_f.len;
            end
          end
        end
        S_CP0: begin
          // Leave one tail hole after the packed segments, or none when no page is free
          for (int i = 0; i < NH; i++) hole_ctl[i].sel = ffa_pkg::CELL_CLEAR;
          if (used < total_pages) begin
            hole_ctl[0] = '{sel: ffa_pkg::CELL_LOAD,
                            data: '{valid: 1'b1, base: used[11:0],
                                    len: total_pages - used}};
            hole_n_next = 5'd1;
          end else begin
            hole_n_next = '0;
          end
          run_next   = '0;
          k_next     = '0;
          state_next = (seg_n == 5'd0) ? S_CPZ : S_CP1;
        end
        S_CP1: begin
          // Move one segment down and report it
          if (can_emit) begin
            for (int i = 0; i < NS; i++)
              if (4'(i) == k)
                seg_ctl[i] = '{sel: ffa_pkg::CELL_LOAD,
                               data: '{valid: 1'b1, pid: seg_k.pid, base: run[11:0],
                                       len: seg_k.len}};
            emit     = 1'b1;
            e_addr   = run[11:0];
            e_src    = seg_k.base;
            e_cnt    = seg_k.len;
            e_last   = ({1'b0, k} + 5'd1 == seg_n);
            run_next = run + seg_k.len;
            k_next   = k + 4'd1;
            if (e_last) state_next = S_IDLE;
          end
        end
        S_CPZ: begin
          if (can_emit) begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seg_n       <= '0;
      hole_n      <= 5'd1;
      free_total  <= 13'(ffa_pkg::MAX_PAGES);
      total_pages <= 13'(ffa_pkg::MAX_PAGES);
    end else begin
      state       <= state_next;
      seg_n       <= seg_n_next;
      hole_n      <= hole_n_next;
      free_total  <= free_next;
      total_pages <= total_next;
    end
    op_pid    <= op_pid_next;
    op_req    <= op_req_next;
    op_lp     <= op_lp_next;
    idx_f     <= idx_f_next;
    h_idx     <= h_idx_next;
    h_base    <= h_base_next;
    h_len     <= h_len_next;
    r_base    <= r_base_next;
    r_len     <= r_len_next;
    left_ent  <= left_next;
    right_ent <= right_next;
    run       <= run_next;
    k         <= k_next;
  end

  // Output register: load a result item, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (emit) begin
      m_axis_tdata <= {4'd0, free_next, e_cnt, e_src, e_addr, e_status};
      m_axis_tlast <= e_last;
    end
  end

`ifndef SYNTH
  a_seg_count: assert property (@(posedge clk) disable iff (rst)
    $countones(seg_vld) == 32'(seg_n))
    else $error("segment count disagrees with valid cells");

  a_hole_count: assert property (@(posedge clk) disable iff (rst)
    $countones(hole_vld) == 32'(hole_n))
    else $error("hole count disagrees with valid cells");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= total_pages)
    else $error("free pages exceed the managed space");

  a_no_emit_full: assert property (@(posedge clk) disable iff (rst)
    emit |-> can_emit)
    else $error("result produced while output register is occupied");
`endif

endmodule

// ===== design/ffa_seg_cell.sv =====
// One cell of the used-segment chain: holds one entry, shifts with its neighbours.
module ffa_seg_cell (
  input  logic                clk,
  input  ffa_pkg::seg_ctl_t   ctl,
  input  ffa_pkg::seg_entry_t prev_ent,
  input  ffa_pkg::seg_entry_t next_ent,
  output ffa_pkg::seg_entry_t ent
);

  // Hold, shift in from a neighbour, load or drop the entry
  always_ff @(posedge clk) begin
    case (ctl.sel)
      ffa_pkg::CELL_PREV:  ent <= prev_ent;
      ffa_pkg::CELL_NEXT:  ent <= next_ent;
      ffa_pkg::CELL_LOAD:  ent <= ctl.data;
      ffa_pkg::CELL_CLEAR: ent.valid <= 1'b0;
      default:             ent <= ent;
    endcase
  end

endmodule

// ===== design/ffa_hole_cell.sv =====
// One cell of the free-hole chain: holds one hole, shifts with its neighbours.
module ffa_hole_cell (
  input  logic                 clk,
  input  ffa_pkg::hole_ctl_t   ctl,
  input  ffa_pkg::hole_entry_t prev_ent,
  input  ffa_pkg::hole_entry_t next_ent,
  output ffa_pkg::hole_entry_t ent
);

  // Hold, shift in from a neighbour, load or drop the hole
  always_ff @(posedge clk) begin
    case (ctl.sel)
      ffa_pkg::CELL_PREV:  ent <= prev_ent;
      ffa_pkg::CELL_NEXT:  ent <= next_ent;
      ffa_pkg::CELL_LOAD:  ent <= ctl.data;
      ffa_pkg::CELL_CLEAR: ent.valid <= 1'b0;
      default:             ent <= ent;
    endcase
  end

endmodule

// ===== tb/first_fit_page_segment_allocator_tb.sv =====
// Testbench for the first-fit page segment allocator: random operation streams against a predictor.
`timescale 1ns / 100ps

module first_fit_page_segment_allocator_tb;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pid;
    logic [12:0] req;
    logic [11:0] lpage;
  } op_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] addr;
    logic [11:0] src;
    logic [12:0] count;
    logic [12:0] free_pg;
    logic        last;
  } alloc_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_wr_en;
  logic [12:0] cfg_wr_data;

  first_fit_page_segment_allocator i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state
  int unsigned space_pages;
  int unsigned seg_pid_q[$];
  int unsigned seg_base_q[$];
  int unsigned seg_len_q[$];
  int unsigned hole_base_q[$];
  int unsigned hole_len_q[$];
  int unsigned free_count;

  op_item_t      pending_ops[$];
  alloc_result_t expected_results[$];
  int            mismatch_count;
  bit            idle_off;
  bit            hold_sink;

  task automatic reset_space();
    seg_pid_q.delete(); seg_base_q.delete(); seg_len_q.delete();
    hole_base_q.delete(); hole_len_q.delete();
    hole_base_q.push_back(0); hole_len_q.push_back(space_pages);
    free_count = space_pages;
  endtask

  function automatic alloc_result_t mk_result(logic [1:0] st, int unsigned addr,
                                              int unsigned src, int unsigned cnt, bit lst);
    alloc_result_t r;
    r.status = st; r.addr = addr[11:0]; r.src = src[11:0]; r.count = cnt[12:0];
    r.free_pg = free_count[12:0]; r.last = lst;
    return r;
  endfunction

  function automatic int pid_slot(int unsigned pid);
    foreach (seg_pid_q[i]) if (seg_pid_q[i] == pid) return i;
    return -1;
  endfunction

  // Work out the results of one operation and update the predicted space
  task automatic predict_op(op_item_t it);
    int unsigned base, len, run;
    int i, j, f;
    bit left, right;
    case (it.op)
      ffa_pkg::OP_ALLOCATE: begin
        if (seg_pid_q.size() >= ffa_pkg::MAX_SEGMENTS) begin
          expected_results.push_back(mk_result(ffa_pkg::ST_TABLE_FULL, 0, 0, 0, 1));
        end else begin
          f = -1;
          if (it.req != 0)
            foreach (hole_len_q[k]) if (f < 0 && hole_len_q[k] >= it.req) f = k;
          if (f < 0) begin
            expected_results.push_back(mk_result(ffa_pkg::ST_NO_HOLE, 0, 0, 0, 1));
          end else begin
            base = hole_base_q[f];
            if (hole_len_q[f] == it.req) begin
              hole_base_q.delete(f); hole_len_q.delete(f);
            end else begin
              hole_base_q[f] += it.req; hole_len_q[f] -= it.req;
            end
            j = 0;
            while (j < seg_base_q.size() && seg_base_q[j] < base) j++;
            seg_pid_q.insert(j, it.pid); seg_base_q.insert(j, base);
            seg_len_q.insert(j, it.req);
            free_count -= it.req;
            expected_results.push_back(mk_result(ffa_pkg::ST_OK, base, 0, it.req, 1));
          end
        end
      end
      ffa_pkg::OP_RELEASE, ffa_pkg::OP_TRANSLATE: begin
        f = pid_slot(it.pid);
        if (f < 0) begin
          expected_results.push_back(mk_result(ffa_pkg::ST_NOT_FOUND, 0, 0, 0, 1));
        end else if (it.op == ffa_pkg::OP_TRANSLATE) begin
          expected_results.push_back(mk_result(ffa_pkg::ST_OK, seg_base_q[f] + it.lpage, 0,
                                               seg_len_q[f], 1));
        end else begin
          base = seg_base_q[f]; len = seg_len_q[f];
          seg_pid_q.delete(f); seg_base_q.delete(f); seg_len_q.delete(f);
          i = 0;
          while (i < hole_base_q.size() && hole_base_q[i] < base) i++;
          left = i > 0 && hole_base_q[i-1] + hole_len_q[i-1] == base;
          right = i < hole_base_q.size() && base + len == hole_base_q[i];
          if (left && right) begin
            hole_len_q[i-1] += len + hole_len_q[i];
            hole_base_q.delete(i); hole_len_q.delete(i);
          end else if (left) begin
            hole_len_q[i-1] += len;
          end else if (right) begin
            hole_base_q[i] = base; hole_len_q[i] += len;
          end else if (hole_base_q.size() < ffa_pkg::HOLE_DEPTH) begin
            hole_base_q.insert(i, base); hole_len_q.insert(i, len);
          end
          free_count += len;
          expected_results.push_back(mk_result(ffa_pkg::ST_OK, base, 0, len, 1));
        end
      end
      default: begin
        run = 0;
        foreach (seg_len_q[k]) run += seg_len_q[k];
        hole_base_q.delete(); hole_len_q.delete();
        free_count = run < space_pages ? space_pages - run : 0;
        if (run < space_pages) begin
          hole_base_q.push_back(run); hole_len_q.push_back(space_pages - run);
        end
        if (seg_pid_q.size() == 0) begin
          expected_results.push_back(mk_result(ffa_pkg::ST_OK, 0, 0, 0, 1));
        end else begin
          run = 0;
          foreach (seg_base_q[k]) begin
            expected_results.push_back(mk_result(ffa_pkg::ST_OK, run, seg_base_q[k],
                                                 seg_len_q[k],
                                                 k + 1 == seg_base_q.size()));
            seg_base_q[k] = run;
            run += seg_len_q[k];
          end
        end
      end
    endcase
  endtask

  function automatic op_item_t mk_op(logic [1:0] op, int unsigned pid, int unsigned req,
                                     int unsigned lp);
    op_item_t it;
    it.op = op; it.pid = pid[15:0]; it.req = req[12:0]; it.lpage = lp[11:0];
    return it;
  endfunction

  // Random operation mostly aimed at live pids and fitting sizes
  function automatic op_item_t rand_op(int unsigned pages);
    int unsigned r, pid, req;
    r = $urandom_range(0, 99);
    pid = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) pid = $urandom;
    if ($urandom_range(0, 9) == 0) req = $urandom_range(0, 8191);
    else req = $urandom_range(1, pages / 6 + 1);
    if (r < 45) return mk_op(ffa_pkg::OP_ALLOCATE, pid, req, 0);
    if (r < 70) return mk_op(ffa_pkg::OP_RELEASE, pid, 0, $urandom);
    if (r < 80) return mk_op(ffa_pkg::OP_COMPACT, $urandom, $urandom, $urandom);
    return mk_op(ffa_pkg::OP_TRANSLATE, pid, $urandom, $urandom);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offer queued items with random gaps
  int src_gap;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= ffa_pkg::OP_ALLOCATE;
      src_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending_ops.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_ops[0].op;
        s_axis_tdata <= {7'd0, pending_ops[0].lpage, pending_ops[0].req, pending_ops[0].pid};
        predict_op(pending_ops.pop_front());
        if (!idle_off && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: ready with random stalls, check each result item
  int sink_gap;
  alloc_result_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[1:0], m_axis_tdata[13:2], m_axis_tdata[25:14],
               m_axis_tdata[38:26], m_axis_tdata[51:39], m_axis_tlast};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("ERROR: unexpected result item %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: result mismatch expected %p actual %p", want, got);
          end
        end
      end
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        m_axis_tready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else if (!idle_off && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        sink_gap <= $urandom_range(0, 11);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Wait for every queued item to go in and every result to come out
  task automatic drain();
    while (pending_ops.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_pages(int unsigned v);
    int unsigned sat;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[12:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sat = v == 0 ? 1 : (v > ffa_pkg::MAX_PAGES ? ffa_pkg::MAX_PAGES : v);
    space_pages = sat;
    reset_space();
  endtask

  // Stimulus
  initial begin
    int unsigned sizes[5];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    mismatch_count = 0;
    idle_off = 0;
    hold_sink = 0;
    space_pages = ffa_pkg::MAX_PAGES;
    reset_space();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: edges of every field and each special case
    pending_ops.push_back(mk_op(ffa_pkg::OP_COMPACT, 0, 0, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_ALLOCATE, 16'hFFFF, 0, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_ALLOCATE, 1, 8191, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_ALLOCATE, 16'hFFFF, 4096, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_TRANSLATE, 16'hFFFF, 0, 4095));
    pending_ops.push_back(mk_op(ffa_pkg::OP_ALLOCATE, 2, 1, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_COMPACT, 0, 0, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_RELEASE, 16'hFFFF, 0, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_RELEASE, 16'hFFFF, 0, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_TRANSLATE, 5, 0, 0));
    for (int k = 0; k < 17; k++)
      pending_ops.push_back(mk_op(ffa_pkg::OP_ALLOCATE, k & 3, 3, 4095));
    drain();
    // Release in a pattern that opens two holes, then merges a segment on both sides
    pending_ops.push_back(mk_op(ffa_pkg::OP_RELEASE, 1, 0, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_RELEASE, 3, 0, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_RELEASE, 2, 0, 0));
    pending_ops.push_back(mk_op(ffa_pkg::OP_COMPACT, 0, 0, 0));
    drain();

    // Random phases across several space sizes, the extremes among them
    sizes = '{1, 8191, 37, 4096, 200};
    foreach (sizes[p]) begin
      write_pages(sizes[p]);
      for (int k = 0; k < 55; k++) pending_ops.push_back(rand_op(space_pages));
      if (p == 1) begin
        // Hold off the sink so the block backs up on its input
        hold_sink = 1;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      if (p == 3) idle_off = 1;
      drain();
    end
    write_pages(0);
    for (int k = 0; k < 20; k++) pending_ops.push_back(rand_op(4));
    drain();

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ffa_pkg.sv
design/ffa_seg_cell.sv
design/ffa_hole_cell.sv
design/first_fit_page_segment_allocator.sv
tb/first_fit_page_segment_allocator_tb.sv
